### sv/positional_list_store_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the positional list store unit
// Shared property wrappers with clock and reset handled in one place.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_STORE_UNIT_DEFINES_SVH
`define POSITIONAL_LIST_STORE_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define PLSU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("plsu assertion failed");

// Next-cycle implication, checked out of reset
`define PLSU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("plsu assertion failed");

`endif

### sv/plsu_pkg.sv
// ----------------------------------------------------------------------------
// Positional list store package
// Sizes, operation and status codes, and the control bundle sent to cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package plsu_pkg;

	localparam int CAPACITY = 64;
	localparam int DATA_W   = 32;
	localparam int FUNC_W   = 3;
	localparam int POS_W    = 7;
	localparam int FOUND_W  = 7;
	localparam int COUNT_W  = 7;
	localparam int STAT_W   = 2;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CMP_W    = (POS_W > CNT_W) ? POS_W : CNT_W;

	// Search miss reads as -1 on the signed position field
	localparam logic [FOUND_W-1:0] NOT_FOUND = {FOUND_W{1'b1}};

	typedef enum logic [FUNC_W-1:0] {
		FN_READ   = 3'd0,
		FN_WRITE  = 3'd1,
		FN_INSERT = 3'd2,
		FN_REMOVE = 3'd3,
		FN_SEARCH = 3'd4,
		FN_CLEAR  = 3'd5
	} func_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK   = 2'd0,
		ST_POS  = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef struct packed {
		logic              acc;
		logic              wr_en;
		logic              ins_en;
		logic              rem_en;
		logic              rd_en;
		logic              srch_en;
		logic [DATA_W-1:0] value;
	} cell_ctrl_t;

endpackage

### sv/positional_list_store_unit.sv
// ----------------------------------------------------------------------------
// Positional list store unit
// The cells register read hits and search matches at the accepting edge; the
// output register loads from the collector when the output is not stalled.
// Throughput: one item per cycle while the output is not stalled; the cell row
// shifts, writes, compares and registers its hits in the accept cycle.
// Reset: arst_n clears the count and both valid flags; entries stay unknown.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "positional_list_store_unit_defines.svh"

module positional_list_store_unit import plsu_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [FUNC_W-1:0]         func,
	input  logic [POS_W-1:0]          pos,
	input  logic signed [DATA_W-1:0]  value,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [DATA_W-1:0]  data_out,
	output logic signed [FOUND_W-1:0] found_pos,
	output logic [COUNT_W-1:0]        count_out,
	output logic [STAT_W-1:0]         status
);

	logic [CNT_W-1:0]    count_q;
	logic                valid_s1;
	func_t               op_s1;
	status_t             status_s1;
	logic [CNT_W-1:0]    count_s1;

	logic                out_valid_q;
	logic [DATA_W-1:0]   data_out_q;
	logic [FOUND_W-1:0]  found_pos_q;
	logic [COUNT_W-1:0]  count_out_q;
	status_t             status_q;

	logic                in_acc;
	logic                adv_s1;
	status_t             in_status;
	logic                op_ok;
	logic [CMP_W-1:0]    pos_x;
	logic [CMP_W-1:0]    cnt_x;
	logic [CNT_W-1:0]    count_nxt;
	cell_ctrl_t          ctrl;

	logic [DATA_W-1:0]   entry  [CAPACITY];
	logic [DATA_W-1:0]   hit    [CAPACITY];
	logic [CAPACITY-1:0] match;
	logic [DATA_W-1:0]   rd_data;
	logic                any_match;
	logic [IDX_W-1:0]    first_idx;

	logic                out_full;
	logic                out_err;

	assign adv_s1   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv_s1;
	assign in_acc   = in_valid && !in_stall;

	assign pos_x = CMP_W'(pos);
	assign cnt_x = CMP_W'(count_q);

	always_comb begin
		in_status = ST_OK;
		case (func)
			FN_READ, FN_WRITE, FN_REMOVE: begin
				if (!(pos_x < cnt_x)) in_status = ST_POS;
			end
			FN_INSERT: begin
				if (pos_x > cnt_x) begin
					in_status = ST_POS;
				end else if (count_q == CNT_W'(CAPACITY)) begin
					in_status = ST_FULL;
				end
			end
			default: in_status = ST_OK;
		endcase
	end

	assign op_ok = in_acc && (in_status == ST_OK);

	always_comb begin
		ctrl.acc     = in_acc;
		ctrl.wr_en   = op_ok && (func == FN_WRITE);
		ctrl.ins_en  = op_ok && (func == FN_INSERT);
		ctrl.rem_en  = op_ok && (func == FN_REMOVE);
		ctrl.rd_en   = op_ok && ((func == FN_READ) || (func == FN_REMOVE));
		ctrl.srch_en = op_ok && (func == FN_SEARCH);
		ctrl.value   = value;
	end

	always_comb begin
		count_nxt = count_q;
		if (op_ok) begin
			case (func)
				FN_INSERT: count_nxt = count_q + CNT_W'(1);
				FN_REMOVE: count_nxt = count_q - CNT_W'(1);
				FN_CLEAR:  count_nxt = '0;
				default:   count_nxt = count_q;
			endcase
		end
	end

	genvar gi;
	generate
		for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
			logic [DATA_W-1:0] left_entry;
			logic [DATA_W-1:0] right_entry;

			if (gi == 0) begin : g_first
				assign left_entry = entry[gi];
			end else begin : g_mid_l
				assign left_entry = entry[gi-1];
			end
			if (gi == CAPACITY - 1) begin : g_last
				assign right_entry = entry[gi];
			end else begin : g_mid_r
				assign right_entry = entry[gi+1];
			end

			plsu_cell u_cell (
				.clk         (clk),
				.ctrl        (ctrl),
				.at_pos      (pos_x == CMP_W'(gi)),
				.past_pos    (pos_x < CMP_W'(gi)),
				.live        (CMP_W'(gi) < cnt_x),
				.left_entry  (left_entry),
				.right_entry (right_entry),
				.entry       (entry[gi]),
				.hit_s1      (hit[gi]),
				.match_s1    (match[gi])
			);
		end
	endgenerate

	plsu_collect u_collect (
		.hit       (hit),
		.match     (match),
		.rd_data   (rd_data),
		.any_match (any_match),
		.first_idx (first_idx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_nxt;
			if (in_acc) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_s1     <= func_t'(func);
			status_s1 <= in_status;
			count_s1  <= count_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			data_out_q  <= rd_data;
			count_out_q <= COUNT_W'(count_s1);
			status_q    <= status_s1;
			if (op_s1 == FN_SEARCH) begin
				found_pos_q <= any_match ? FOUND_W'(first_idx) : NOT_FOUND;
			end else begin
				found_pos_q <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign data_out  = data_out_q;
	assign found_pos = found_pos_q;
	assign count_out = count_out_q;
	assign status    = status_q;

	assign out_full = out_valid_q && (status_q == ST_FULL);
	assign out_err  = out_valid_q && (status_q != ST_OK);

	`PLSU_ASSERT_NOW(a_count_cap, clk, arst_n, 1'b1, count_q <= CNT_W'(CAPACITY))
	`PLSU_ASSERT_NOW(a_full_count, clk, arst_n, out_full, count_out_q == COUNT_W'(CAPACITY))
	`PLSU_ASSERT_NEXT(a_clear_empty, clk, arst_n, in_acc && (func == FN_CLEAR), count_q == '0)
	`PLSU_ASSERT_NOW(a_bad_pos_zero, clk, arst_n, out_err, data_out_q == '0)

endmodule

### sv/plsu_cell.sv
// ----------------------------------------------------------------------------
// List cell
// Holds one entry, shifts with its neighbors and flags read and search hits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module plsu_cell import plsu_pkg::*; (
	input  logic              clk,
	input  cell_ctrl_t        ctrl,
	input  logic              at_pos,
	input  logic              past_pos,
	input  logic              live,
	input  logic [DATA_W-1:0] left_entry,
	input  logic [DATA_W-1:0] right_entry,
	output logic [DATA_W-1:0] entry,
	output logic [DATA_W-1:0] hit_s1,
	output logic              match_s1
);

	logic [DATA_W-1:0] entry_q;
	logic [DATA_W-1:0] hit_q;
	logic              match_q;

	always_ff @(posedge clk) begin
		if (ctrl.ins_en && past_pos) begin
			entry_q <= left_entry;
		end else if ((ctrl.ins_en || ctrl.wr_en) && at_pos) begin
			entry_q <= ctrl.value;
		end else if (ctrl.rem_en && (at_pos || past_pos)) begin
			entry_q <= right_entry;
		end
	end

	// Sample old contents, so a remove still returns the entry it drops
	always_ff @(posedge clk) begin
		if (ctrl.acc) begin
			hit_q   <= (ctrl.rd_en && at_pos) ? entry_q : '0;
			match_q <= ctrl.srch_en && live && (entry_q == ctrl.value);
		end
	end

	assign entry    = entry_q;
	assign hit_s1   = hit_q;
	assign match_s1 = match_q;

endmodule

### sv/plsu_collect.sv
// ----------------------------------------------------------------------------
// Hit collector
// Merges the cells' read hits and encodes the lowest matching position.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module plsu_collect import plsu_pkg::*; (
	input  logic [DATA_W-1:0]   hit   [CAPACITY],
	input  logic [CAPACITY-1:0] match,
	output logic [DATA_W-1:0]   rd_data,
	output logic                any_match,
	output logic [IDX_W-1:0]    first_idx
);

	logic [CAPACITY-1:0] lowest;

	// Isolate the lowest set bit
	assign lowest    = match & (~match + CAPACITY'(1));
	assign any_match = |match;

	always_comb begin
		rd_data   = '0;
		first_idx = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			rd_data = rd_data | hit[i];
			if (lowest[i]) begin
				first_idx = first_idx | IDX_W'(i);
			end
		end
	end

endmodule
